@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, aborted while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// implication after a fixed number of cycles, aborted while reset is high
`define ASSERT_DELAYED(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("delayed check failed");

`endif

@@ rtl/toam_pkg.sv @@
// ----------------------------------------------------------------------------
// toam_pkg
// widths, constants and helpers of the tetrahedral multilateration solver
// ----------------------------------------------------------------------------
package toam_pkg;

   localparam int DIST_BITS       = 16;
   localparam int COORD_FRAC_BITS = 16;
   localparam int REQ_W           = 16;
   localparam int EDGE_W          = 16;
   localparam int POS_W           = 32;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;

   localparam logic [EDGE_W-1:0] EDGE_RESET = 16'd1000;

   // csr word index
   localparam logic REG_EDGE = 1'b0;

   // datapath widths
   localparam int SQ_W   = 2 * DIST_BITS;
   localparam int VAL_W  = SQ_W + 3;
   localparam int MAG_W  = SQ_W + 2;
   localparam int ROOT_W = COORD_FRAC_BITS + 2;
   localparam int PROD_W = MAG_W + ROOT_W;
   localparam int DEN_W  = EDGE_W + COORD_FRAC_BITS;
   localparam int D2_W   = DEN_W + 1;
   localparam int QUO_W  = POS_W - 1;
   localparam int N2_W   = PROD_W + 2;
   localparam int REM_W  = ((N2_W > D2_W + QUO_W) ? N2_W : D2_W + QUO_W) + 1;

   // sqrt3 and sqrt6, rounded from 32-bit fractions
   localparam logic [63:0] ROOT3_Q32  = 64'd7439101574;
   localparam logic [63:0] ROOT6_Q32  = 64'd10520478337;
   localparam logic [63:0] ROOT3_FULL =
      (ROOT3_Q32 + (64'd1 << (31 - COORD_FRAC_BITS))) >> (32 - COORD_FRAC_BITS);
   localparam logic [63:0] ROOT6_FULL =
      (ROOT6_Q32 + (64'd1 << (31 - COORD_FRAC_BITS))) >> (32 - COORD_FRAC_BITS);
   localparam logic [ROOT_W-1:0] ROOT3 = ROOT3_FULL[ROOT_W-1:0];
   localparam logic [ROOT_W-1:0] ROOT6 = ROOT6_FULL[ROOT_W-1:0];

   // lanes of the solver
   localparam int LANES  = 3;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   localparam int DIV_STAGES = QUO_W;
   localparam int PIPE_LAT   = DIV_STAGES + 7;

   typedef logic [REM_W-1:0] rem_type;
   typedef logic [QUO_W-1:0] quo_type;
   typedef logic [POS_W-1:0] pos_type;

   // saturate a rounded magnitude to a signed coordinate
   function automatic pos_type sat_pos(input logic over, input logic neg, input quo_type q);
      pos_type mag;
      mag = {1'b0, q};
      if (over) begin
         sat_pos = neg ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         sat_pos = neg ? (~mag + pos_type'(1)) : mag;
      end
   endfunction

endpackage

@@ rtl/toa_tetrahedral_multilateration.sv @@
// ----------------------------------------------------------------------------
// toa_tetrahedral_multilateration
// four-anchor time-of-arrival solver, pipelined, one beat per cycle
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req_dist_*    beat taken when start && !busy
//  response  rsp_valid, rsp_pos_*, ...  one-cycle strobe, no backpressure
//  csr       psel ... pready            apb write on psel&penable&pwrite
//
// one beat enters every cycle, busy is never raised
// a result leaves once its beat has passed six arithmetic stages,
// one stage per quotient bit of the restoring divider and one output stage
// reset is synchronous and clears valid bits and the edge register
// the receiver cannot stall, so the pipeline never holds
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module toa_tetrahedral_multilateration (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [toam_pkg::REQ_W-1:0]              req_dist_front,
   input  logic [toam_pkg::REQ_W-1:0]              req_dist_left_back,
   input  logic [toam_pkg::REQ_W-1:0]              req_dist_right_back,
   input  logic [toam_pkg::REQ_W-1:0]              req_dist_top,
   output logic                                    rsp_valid,
   output logic signed [toam_pkg::POS_W-1:0]       rsp_pos_x,
   output logic signed [toam_pkg::POS_W-1:0]       rsp_pos_y,
   output logic signed [toam_pkg::POS_W-1:0]       rsp_pos_z,
   output logic                                    rsp_singular,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [toam_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [toam_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [toam_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);

   localparam int LANES  = toam_pkg::LANES;
   localparam int DIVS   = toam_pkg::DIV_STAGES;
   localparam int LAT    = toam_pkg::PIPE_LAT;
   localparam int FRAC   = toam_pkg::COORD_FRAC_BITS;

   // ---------------- csr ----------------
   logic [toam_pkg::EDGE_W-1:0] edge_ff;
   logic                        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == toam_pkg::REG_EDGE);
   assign prdata = (paddr[2] == toam_pkg::REG_EDGE) ?
                   toam_pkg::CSR_DATA_W'(edge_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= toam_pkg::EDGE_RESET;
      end else if (csr_wr) begin
         edge_ff <= pwdata[toam_pkg::EDGE_W-1:0];
      end
   end

   // the pipeline never holds a beat
   assign busy = 1'b0;

   // valid and singular flags walk alongside the data
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] sing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      sing_ff <= {sing_ff[LAT-2:0], (edge_ff == '0)};
   end

   // ---------------- stage 1: squares ----------------
   logic [toam_pkg::SQ_W-1:0]   sq_ff [4];
   logic [toam_pkg::EDGE_W-1:0] edge1_ff, edge2_ff, edge3_ff;
   logic [toam_pkg::DIST_BITS-1:0] d0, d1, d2, d3;

   assign d0 = req_dist_front[toam_pkg::DIST_BITS-1:0];
   assign d1 = req_dist_left_back[toam_pkg::DIST_BITS-1:0];
   assign d2 = req_dist_right_back[toam_pkg::DIST_BITS-1:0];
   assign d3 = req_dist_top[toam_pkg::DIST_BITS-1:0];

   always_ff @(posedge clock) begin
      sq_ff[0] <= toam_pkg::SQ_W'(d0) * toam_pkg::SQ_W'(d0);
      sq_ff[1] <= toam_pkg::SQ_W'(d1) * toam_pkg::SQ_W'(d1);
      sq_ff[2] <= toam_pkg::SQ_W'(d2) * toam_pkg::SQ_W'(d2);
      sq_ff[3] <= toam_pkg::SQ_W'(d3) * toam_pkg::SQ_W'(d3);
      edge1_ff <= edge_ff;
   end

   // ---------------- stage 2: cramer numerators ----------------
   // x ~ sq1 - sq2, y ~ 2sq0 - sq1 - sq2, z ~ sq0 + sq1 + sq2 - 3sq3
   logic signed [toam_pkg::VAL_W-1:0] s0, s1, s2, s3;
   logic signed [toam_pkg::VAL_W-1:0] val_in [LANES];
   logic signed [toam_pkg::VAL_W-1:0] val_ff [LANES];

   assign s0 = signed'(toam_pkg::VAL_W'(sq_ff[0]));
   assign s1 = signed'(toam_pkg::VAL_W'(sq_ff[1]));
   assign s2 = signed'(toam_pkg::VAL_W'(sq_ff[2]));
   assign s3 = signed'(toam_pkg::VAL_W'(sq_ff[3]));

   assign val_in[toam_pkg::LANE_X] = s1 - s2;
   assign val_in[toam_pkg::LANE_Y] = s0 + s0 - s1 - s2;
   assign val_in[toam_pkg::LANE_Z] = s0 + s1 + s2 - s3 - s3 - s3;

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      edge2_ff <= edge1_ff;
   end

   // ---------------- stage 3: sign and magnitude ----------------
   // y is negated by the geometry, so its sign is set for positive sums
   logic [toam_pkg::MAG_W-1:0] mag_ff  [LANES];
   logic                       neg3_ff [LANES];

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         mag_ff[l] <= val_ff[l][toam_pkg::VAL_W-1] ?
                      toam_pkg::MAG_W'(-val_ff[l]) : toam_pkg::MAG_W'(val_ff[l]);
      end
      neg3_ff[toam_pkg::LANE_X] <= val_ff[toam_pkg::LANE_X][toam_pkg::VAL_W-1];
      neg3_ff[toam_pkg::LANE_Y] <= !val_ff[toam_pkg::LANE_Y][toam_pkg::VAL_W-1] &&
                                   (val_ff[toam_pkg::LANE_Y] != '0);
      neg3_ff[toam_pkg::LANE_Z] <= val_ff[toam_pkg::LANE_Z][toam_pkg::VAL_W-1];
      edge3_ff <= edge2_ff;
   end

   // ---------------- stage 4: scale y and z by roots and x by eight, build divisors ----------------
   logic [toam_pkg::PROD_W-1:0] num_ff  [LANES];
   logic [toam_pkg::DEN_W-1:0]  den_ff  [LANES];
   logic                        neg4_ff [LANES];
   logic [toam_pkg::DEN_W-1:0]  edge3x;

   assign edge3x = toam_pkg::DEN_W'(edge3_ff) + (toam_pkg::DEN_W'(edge3_ff) << 1);

   always_ff @(posedge clock) begin
      num_ff[toam_pkg::LANE_X] <= toam_pkg::PROD_W'(mag_ff[toam_pkg::LANE_X]) << 3;
      num_ff[toam_pkg::LANE_Y] <= toam_pkg::PROD_W'(mag_ff[toam_pkg::LANE_Y]) *
                                  toam_pkg::PROD_W'(toam_pkg::ROOT3);
      num_ff[toam_pkg::LANE_Z] <= toam_pkg::PROD_W'(mag_ff[toam_pkg::LANE_Z]) *
                                  toam_pkg::PROD_W'(toam_pkg::ROOT6);
      den_ff[toam_pkg::LANE_X] <= toam_pkg::DEN_W'(edge3_ff);
      den_ff[toam_pkg::LANE_Y] <= edge3x << (FRAC - 3);
      den_ff[toam_pkg::LANE_Z] <= edge3x << (FRAC - 2);
      neg4_ff <= neg3_ff;
   end

   // ---------------- stage 5: rounding offset ----------------
   // round(n/d) half up = floor((2n + d) / 2d)
   toam_pkg::rem_type          n2_ff   [LANES];
   logic [toam_pkg::D2_W-1:0]  d2s_ff  [LANES];
   logic                       neg5_ff [LANES];

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         n2_ff[l]  <= (toam_pkg::REM_W'(num_ff[l]) << 1) + toam_pkg::REM_W'(den_ff[l]);
         d2s_ff[l] <= toam_pkg::D2_W'(den_ff[l]) << 1;
      end
      neg5_ff <= neg4_ff;
   end

   // ---------------- stage 6 and divider ----------------
   // index 0 is the overflow check, then one quotient bit per stage, msb first
   toam_pkg::rem_type          rem_ff  [LANES][DIVS+1];
   toam_pkg::quo_type          quo_ff  [LANES][DIVS+1];
   logic [toam_pkg::D2_W-1:0]  d2_ff   [LANES][DIVS+1];
   logic                       over_ff [LANES][DIVS+1];
   logic                       neg_ff  [LANES][DIVS+1];

   for (genvar l = 0; l < LANES; l++) begin : g_div_head
      always_ff @(posedge clock) begin
         rem_ff[l][0]  <= n2_ff[l];
         quo_ff[l][0]  <= '0;
         d2_ff[l][0]   <= d2s_ff[l];
         over_ff[l][0] <= n2_ff[l] >= (toam_pkg::REM_W'(d2s_ff[l]) << DIVS);
         neg_ff[l][0]  <= neg5_ff[l];
      end
   end

   for (genvar k = 1; k <= DIVS; k++) begin : g_div
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         toam_pkg::rem_type sub_val;
         logic              take;

         assign sub_val = toam_pkg::REM_W'(d2_ff[l][k-1]) << (DIVS - k);
         assign take    = rem_ff[l][k-1] >= sub_val;

         always_ff @(posedge clock) begin
            rem_ff[l][k]  <= take ? (rem_ff[l][k-1] - sub_val) : rem_ff[l][k-1];
            quo_ff[l][k]  <= quo_ff[l][k-1] |
                             (take ? (toam_pkg::QUO_W'(1) << (DIVS - k)) : '0);
            d2_ff[l][k]   <= d2_ff[l][k-1];
            over_ff[l][k] <= over_ff[l][k-1];
            neg_ff[l][k]  <= neg_ff[l][k-1];
         end
      end
   end

   // ---------------- output stage ----------------
   toam_pkg::pos_type pos_ff [LANES];

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         pos_ff[l] <= sing_ff[LAT-2] ? '0 :
                      toam_pkg::sat_pos(over_ff[l][DIVS], neg_ff[l][DIVS], quo_ff[l][DIVS]);
      end
   end

   assign rsp_valid    = vld_ff[LAT-1];
   assign rsp_singular = sing_ff[LAT-1];
   assign rsp_pos_x    = signed'(pos_ff[toam_pkg::LANE_X]);
   assign rsp_pos_y    = signed'(pos_ff[toam_pkg::LANE_Y]);
   assign rsp_pos_z    = signed'(pos_ff[toam_pkg::LANE_Z]);

   // ---------------- checks ----------------
   logic                        rsp_zero;
   logic [toam_pkg::EDGE_W-1:0] wr_edge;

   assign rsp_zero = (rsp_pos_x == '0) && (rsp_pos_y == '0) && (rsp_pos_z == '0);
   assign wr_edge  = pwdata[toam_pkg::EDGE_W-1:0];

   `ASSERT_DELAYED(a_fixed_latency, clock, reset, start && !busy, LAT, rsp_valid)
   `ASSERT_IMPLIES(a_singular_zero, clock, reset, rsp_valid && rsp_singular, rsp_zero)
   `ASSERT_DELAYED(a_edge_write, clock, reset, csr_wr, 1, edge_ff == $past(wr_edge))

endmodule
